### rtl/dual_table_pressure_interp_assert.svh
// Assertion macros used by the controller (dtpi_ctrl).
`ifndef DUAL_TABLE_PRESSURE_INTERP_ASSERT_SVH
`define DUAL_TABLE_PRESSURE_INTERP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTPI_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtpi: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DTPI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtpi: next-cycle check failed");

`endif

### rtl/dtpi_pkg.sv
`timescale 1ns / 1ps

package dtpi_pkg;

    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int COUNT_W   = 9;
    localparam int IDX_W     = 8;
    localparam int DATA_W    = 32;

    localparam logic [REQ_W-1:0] REQ_WR_UNREACTED = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WR_REACTED   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY        = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_UNREACTED_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REACTED_COUNT   = 1'b1;

    typedef struct packed {
        logic wr_unr;
        logic wr_rea;
        logic scan_init;
        logic scan_en;
        logic div_init;
        logic div_step;
        logic mul;
        logic sum;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
    } t_lane_sts;

endpackage

### rtl/dtpi_ram.sv
`timescale 1ns / 1ps

module dtpi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/dtpi_lane.sv
`timescale 1ns / 1ps

module dtpi_lane #(
    parameter int TABLE_DEPTH   = 256,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dtpi_pkg::t_cmd                      i_cmd,
    input  logic                                i_wr_en,
    input  logic [dtpi_pkg::IDX_W-1:0]          i_entry_index,
    input  logic [dtpi_pkg::DATA_W-1:0]         i_entry_x,
    input  logic signed [dtpi_pkg::DATA_W-1:0]  i_entry_y,
    input  logic [dtpi_pkg::DATA_W-1:0]         i_query_j,
    input  logic [dtpi_pkg::COUNT_W-1:0]        i_count,
    output dtpi_pkg::t_lane_sts                 o_sts,
    output logic signed [dtpi_pkg::DATA_W-1:0]  o_result
);

    localparam int DW = dtpi_pkg::DATA_W;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int QW = FRACTION_BITS + 1;
    localparam int PW = DW + 1 + QW + 1;

    logic [2*DW-1:0]    rd_data;
    logic [DW-1:0]      rd_x;
    logic [DW-1:0]      rd_y;
    logic               in_range;
    logic [31:0]        cnt32;
    logic [31:0]        n32;
    logic               hit;
    logic               last;
    logic               issue;
    logic [DW:0]        sub;
    logic               qbit;
    logic [DW-1:0]      rem_sel;
    logic signed [DW:0] dy;
    logic signed [QW:0] tq;
    logic signed [PW-1:0] shifted;

    logic [DW-1:0]      r_q;
    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_next;
    logic [CW-1:0]      r_rd_idx;
    logic               r_rd_vld;
    logic               r_done;
    logic               r_first;
    logic               r_end;
    logic [DW-1:0]      r_px;
    logic [DW-1:0]      r_py;
    logic [DW-1:0]      r_cx;
    logic [DW-1:0]      r_cy;
    logic               r_direct;
    logic [DW-1:0]      r_dval;
    logic [DW:0]        r_rem;
    logic [DW-1:0]      r_den;
    logic [QW-1:0]      r_quo;
    logic signed [PW-1:0] r_prod;
    logic [DW-1:0]      r_res;

    assign in_range = 32'(i_entry_index) < 32'(TABLE_DEPTH);

    dtpi_ram #(
        .WIDTH (2 * DW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr_en && in_range),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata ({i_entry_y, i_entry_x}),
        .i_raddr (r_next[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign rd_x = rd_data[DW-1:0];
    assign rd_y = rd_data[2*DW-1:DW];

    always_comb begin
        cnt32 = 32'(i_count);
        if (cnt32 == 32'd0) begin
            n32 = 32'd1;
        end else if (cnt32 > 32'(TABLE_DEPTH)) begin
            n32 = 32'(TABLE_DEPTH);
        end else begin
            n32 = cnt32;
        end
    end

    assign hit   = r_rd_vld && !r_done && (rd_x >= r_q);
    assign last  = r_rd_vld && !r_done && (r_rd_idx == (r_n - CW'(1)));
    assign issue = i_cmd.scan_en && !r_done && !hit && !last && (r_next < r_n);

    assign sub     = r_rem - {1'b0, r_den};
    assign qbit    = r_rem >= {1'b0, r_den};
    assign rem_sel = qbit ? sub[DW-1:0] : r_rem[DW-1:0];

    assign dy      = $signed({r_cy[DW-1], r_cy}) - $signed({r_py[DW-1], r_py});
    assign tq      = $signed({1'b0, r_quo});
    assign shifted = r_prod >>> FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done   <= 1'b0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.scan_init) begin
            r_q      <= i_query_j;
            r_n      <= CW'(n32);
            r_next   <= '0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else if (i_cmd.scan_en) begin
            r_rd_vld <= issue;
            r_rd_idx <= r_next;
            if (issue) begin
                r_next <= r_next + CW'(1);
            end
            if (hit) begin
                r_done  <= 1'b1;
                r_cx    <= rd_x;
                r_cy    <= rd_y;
                r_first <= (r_rd_idx == '0);
                r_end   <= 1'b0;
            end else if (r_rd_vld && !r_done) begin
                r_px <= rd_x;
                r_py <= rd_y;
                if (last) begin
                    r_done  <= 1'b1;
                    r_end   <= 1'b1;
                    r_first <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_direct <= r_first || r_end || (r_cx <= r_px);
            r_dval   <= r_end ? r_py : r_cy;
            r_rem    <= {1'b0, r_q - r_px};
            r_den    <= r_cx - r_px;
            r_quo    <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= {rem_sel, 1'b0};
            r_quo <= {r_quo[QW-2:0], qbit};
        end
        if (i_cmd.mul) begin
            r_prod <= dy * tq;
        end
        if (i_cmd.sum) begin
            r_res <= r_direct ? r_dval : (r_py + shifted[DW-1:0]);
        end
    end

    assign o_sts.scan_done = r_done;
    assign o_result        = r_res;

endmodule

### rtl/dtpi_ctrl.sv
`timescale 1ns / 1ps
`include "dual_table_pressure_interp_assert.svh"

module dtpi_ctrl #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [dtpi_pkg::REQ_W-1:0]   i_req_type,
    input  dtpi_pkg::t_lane_sts          i_sts_unr,
    input  dtpi_pkg::t_lane_sts          i_sts_rea,
    output dtpi_pkg::t_cmd               o_cmd,
    output logic                         o_busy,
    output logic                         o_valid
);

    localparam int SW = $clog2(FRACTION_BITS + 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_MUL,
        S_SUM
    } t_state;

    t_state        r_state;
    logic [SW-1:0] r_step;
    logic          r_busy;
    logic          r_valid;
    logic          accept;
    logic          scans_done;

    assign accept     = i_start && !r_busy;
    assign scans_done = i_sts_unr.scan_done && i_sts_rea.scan_done;

    always_comb begin
        o_cmd           = '0;
        o_cmd.wr_unr    = accept && (i_req_type == dtpi_pkg::REQ_WR_UNREACTED);
        o_cmd.wr_rea    = accept && (i_req_type == dtpi_pkg::REQ_WR_REACTED);
        o_cmd.scan_init = accept && (i_req_type == dtpi_pkg::REQ_QUERY);
        o_cmd.scan_en   = (r_state == S_SCAN);
        o_cmd.div_init  = (r_state == S_SCAN) && scans_done;
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.sum       = (r_state == S_SUM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_req_type == dtpi_pkg::REQ_QUERY)) begin
                        r_state <= S_SCAN;
                        r_busy  <= 1'b1;
                    end
                end
                S_SCAN: begin
                    if (scans_done) begin
                        r_state <= S_DIV;
                        r_step  <= '0;
                    end
                end
                S_DIV: begin
                    r_step <= r_step + SW'(1);
                    if (r_step == SW'(FRACTION_BITS)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_valid <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_valid;

    `DTPI_ASSERT_NEXT(a_valid_single, i_clk, i_rst_n, o_valid, !o_valid)
    `DTPI_ASSERT_IMPL(a_valid_idle, i_clk, i_rst_n, o_valid, !o_busy && (r_state == S_IDLE))
    `DTPI_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, o_cmd.scan_init, o_busy && (r_state == S_SCAN))

endmodule

### rtl/dual_table_pressure_interp.sv
`timescale 1ns / 1ps

// Dual-table pressure interpolator. Write beats (req_type 0 or 1) load one
// entry of a table in the accept cycle and give no result; busy stays low.
// A query beat scans both tables in parallel, one entry per cycle from index
// 0 (one RAM read port per table), then runs a restoring fraction divider
// of FRACTION_BITS+1 steps, one multiply and one add. The scan ends when
// both tables have found their hit or reached their last position (the
// table's count minus one), so the table that scans longer sets when the
// result comes; busy is high while a query runs and falls as o_valid rises.
// o_valid is high for exactly one cycle to flag the result on the pressure
// ports, which must be taken then: there is no way to hold o_valid. The next
// beat may be started in that same cycle.

module dual_table_pressure_interp #(
    parameter int TABLE_DEPTH   = 256,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [dtpi_pkg::REQ_W-1:0]          i_req_type,
    input  logic [dtpi_pkg::IDX_W-1:0]          i_entry_index,
    input  logic [dtpi_pkg::DATA_W-1:0]         i_entry_x,
    input  logic signed [dtpi_pkg::DATA_W-1:0]  i_entry_y,
    input  logic [dtpi_pkg::DATA_W-1:0]         i_query_j,
    input  logic                                i_cfg_we,
    input  logic [dtpi_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dtpi_pkg::COUNT_W-1:0]        i_cfg_wdata,
    output logic                                o_valid,
    output logic signed [dtpi_pkg::DATA_W-1:0]  o_pressure_unreacted,
    output logic signed [dtpi_pkg::DATA_W-1:0]  o_pressure_reacted
);

    dtpi_pkg::t_cmd      cmd;
    dtpi_pkg::t_lane_sts sts_unr;
    dtpi_pkg::t_lane_sts sts_rea;

    logic [dtpi_pkg::COUNT_W-1:0] r_unr_count;
    logic [dtpi_pkg::COUNT_W-1:0] r_rea_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unr_count <= dtpi_pkg::COUNT_W'(1);
            r_rea_count <= dtpi_pkg::COUNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dtpi_pkg::CFG_UNREACTED_COUNT: r_unr_count <= i_cfg_wdata;
                dtpi_pkg::CFG_REACTED_COUNT:   r_rea_count <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    dtpi_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_sts_unr  (sts_unr),
        .i_sts_rea  (sts_rea),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_valid    (o_valid)
    );

    dtpi_lane #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_lane_unr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_wr_en       (cmd.wr_unr),
        .i_entry_index (i_entry_index),
        .i_entry_x     (i_entry_x),
        .i_entry_y     (i_entry_y),
        .i_query_j     (i_query_j),
        .i_count       (r_unr_count),
        .o_sts         (sts_unr),
        .o_result      (o_pressure_unreacted)
    );

    dtpi_lane #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_lane_rea (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_wr_en       (cmd.wr_rea),
        .i_entry_index (i_entry_index),
        .i_entry_x     (i_entry_x),
        .i_entry_y     (i_entry_y),
        .i_query_j     (i_query_j),
        .i_count       (r_rea_count),
        .o_sts         (sts_rea),
        .o_result      (o_pressure_reacted)
    );

endmodule
